### rtl/novd_pkg.sv
// Shared types and constants for the nearest occupied voxel distance core.
// No dependencies; imported by every module of the block.
package novd_pkg;

    localparam int unsigned OffW    = 6;
    localparam int unsigned CfgW    = 28;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned MulW    = 28;
    localparam int unsigned SqW     = 52;
    localparam int unsigned RootW   = 27;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_VOXEL_SIZE  = 3'd0,
        CFG_RANGE_LIMIT = 3'd1,
        CFG_WEIGHT_X    = 3'd2,
        CFG_WEIGHT_Y    = 3'd3,
        CFG_WEIGHT_Z    = 3'd4,
        CFG_UNKNOWN_HIT = 3'd5,
        CFG_SKIP_CENTRE = 3'd6,
        CFG_REPORT_RAW  = 3'd7
    } t_cfg_idx;

    localparam logic [1:0] CLS_OCCUPIED = 2'd1;
    localparam logic [1:0] CLS_UNKNOWN  = 2'd2;

    typedef struct packed {
        logic start;
        logic [SqW-1:0] value;
    } t_sqrt_req;

    typedef struct packed {
        logic done;
        logic [RootW-1:0] root;
    } t_sqrt_rsp;

endpackage

### rtl/novd_mul.sv
// Registered unsigned multiplier shared by every product of the block.
// Depends on novd_pkg for the operand width.
module novd_mul import novd_pkg::*; (
    input  logic              i_clk,
    input  logic [MulW-1:0]   i_a,
    input  logic [MulW-1:0]   i_b,
    output logic [2*MulW-1:0] o_p
);

    logic [2*MulW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

### rtl/novd_sqrt.sv
// Iterative square root, one result bit a cycle, rounded to nearest.
// Depends on novd_pkg for widths and the request and response structs.
module novd_sqrt import novd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sqrt_req i_req,
    output t_sqrt_rsp o_rsp
);

    logic [SqW-1:0] r_v, n_v;
    logic [SqW-1:0] r_res, n_res;
    logic [SqW-1:0] r_bit, n_bit;
    logic [4:0]     r_cnt, n_cnt;
    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [SqW-1:0] trial;

    assign trial = r_res + r_bit;

    always_comb begin
        n_v    = r_v;
        n_res  = r_res;
        n_bit  = r_bit;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_v    = i_req.value;
            n_res  = '0;
            n_bit  = {2'b01, {(SqW-2){1'b0}}};
            n_cnt  = 5'(SqW/2 - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                n_v   = r_v - trial;
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_v   <= n_v;
        r_res <= n_res;
        r_bit <= n_bit;
        r_cnt <= n_cnt;
    end

    // The remainder left in r_v decides the rounding step.
    assign o_rsp.done = r_done;
    assign o_rsp.root = r_res[RootW-1:0] + RootW'(r_v > r_res);

endmodule

### rtl/nearest_occupied_voxel_distance_core.sv
// Nearest occupied voxel distance core: top level with sequencer and state.
// Depends on novd_pkg, novd_mul and novd_sqrt.
// A qualifying voxel uses the shared multiplier for 13 products, then the
// decision; a voxel that does not qualify is taken without that calculation.
// The last voxel of a query adds the square root and the output state.
// Reset is synchronous and active low; it restores the register defaults.
module nearest_occupied_voxel_distance_core import novd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_addr,
    input  logic [CfgW-1:0]    i_cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // offset_x [5:0], offset_y [11:6], offset_z [17:12], voxel_class [19:18], zero pad
    input  logic [23:0]        s_axis_tdata,
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // distance [27:0], zero pad
    output logic [31:0]        m_axis_tdata,
    // found [0]
    output logic               m_axis_tuser
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CALC = 5'b00010,
        ST_ROOT = 5'b00100,
        ST_WAIT = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [15:0] r_voxel_size, r_weight_x, r_weight_y, r_weight_z;
    logic [27:0] r_range_limit;
    logic        r_unknown_hit, r_skip_centre, r_report_raw;

    // Per-voxel working registers.
    logic [OffW-1:0] r_mx, r_my, r_mz;
    logic            r_last;
    logic [3:0]      r_step;
    logic [20:0]     r_sx, r_sy, r_sz;
    logic [24:0]     r_cx, r_cy, r_cz;
    logic [SqW-1:0]  r_raw;
    logic [SqW:0]    r_scl;
    logic [55:0]     r_lim;

    // Query state.
    logic [SqW-1:0]  r_best_scl, r_best_rep;
    logic            r_any;

    // Output register.
    logic            r_out_valid;
    logic [27:0]     r_out_dist;
    logic            r_out_found;

    logic [MulW-1:0]   mul_a, mul_b;
    logic [2*MulW-1:0] mul_p;
    logic [37:0]       round_p;
    t_sqrt_req         sqrt_req;
    t_sqrt_rsp         sqrt_rsp;

    // Input decode: magnitudes of the signed offsets and qualification.
    logic [OffW-1:0] in_x, in_y, in_z, in_mx, in_my, in_mz;
    logic [1:0]      in_cls;
    logic            in_hit, in_centre, in_qualify, in_xfer;

    assign in_x   = s_axis_tdata[5:0];
    assign in_y   = s_axis_tdata[11:6];
    assign in_z   = s_axis_tdata[17:12];
    assign in_cls = s_axis_tdata[19:18];
    assign in_mx  = in_x[OffW-1] ? OffW'(-in_x) : in_x;
    assign in_my  = in_y[OffW-1] ? OffW'(-in_y) : in_y;
    assign in_mz  = in_z[OffW-1] ? OffW'(-in_z) : in_z;
    assign in_hit = (in_cls == CLS_OCCUPIED) || (in_cls == CLS_UNKNOWN && r_unknown_hit);
    assign in_centre  = (in_mx == '0) && (in_my == '0) && (in_mz == '0);
    assign in_qualify = in_hit && !(r_skip_centre && in_centre);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // The product issued in one step is consumed in the next.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_step)
            4'd0:  begin mul_a = MulW'(r_mx); mul_b = MulW'(r_voxel_size); end
            4'd1:  begin mul_a = MulW'(r_my); mul_b = MulW'(r_voxel_size); end
            4'd2:  begin mul_a = MulW'(r_mz); mul_b = MulW'(r_voxel_size); end
            4'd3:  begin mul_a = MulW'(r_sx); mul_b = MulW'(r_sx); end
            4'd4:  begin mul_a = MulW'(r_sy); mul_b = MulW'(r_sy); end
            4'd5:  begin mul_a = MulW'(r_sz); mul_b = MulW'(r_sz); end
            4'd6:  begin mul_a = MulW'(r_sx); mul_b = MulW'(r_weight_x); end
            4'd7:  begin mul_a = MulW'(r_sy); mul_b = MulW'(r_weight_y); end
            4'd8:  begin mul_a = MulW'(r_sz); mul_b = MulW'(r_weight_z); end
            4'd9:  begin mul_a = MulW'(r_cx); mul_b = MulW'(r_cx); end
            4'd10: begin mul_a = MulW'(r_cy); mul_b = MulW'(r_cy); end
            4'd11: begin mul_a = MulW'(r_cz); mul_b = MulW'(r_cz); end
            4'd12: begin mul_a = r_range_limit; mul_b = r_range_limit; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    novd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Weighted separation rounded half up, dropping the 12 fraction bits of the Q.12 weight.
    assign round_p = mul_p[37:0] + 38'd2048;

    // Decision on the finished voxel.
    logic [SqW-1:0] scl_sat, rep;
    logic           in_range, better;

    assign scl_sat  = r_scl[SqW] ? {SqW{1'b1}} : r_scl[SqW-1:0];
    assign rep      = r_report_raw ? r_raw : scl_sat;
    assign in_range = (r_range_limit == '0) || ({4'b0, rep} <= r_lim);
    assign better   = !r_any || (scl_sat < r_best_scl);

    assign sqrt_req.start = (r_state == ST_ROOT);
    assign sqrt_req.value = r_best_rep;

    novd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_rsp   (sqrt_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_xfer) begin
                if (in_qualify)        n_state = ST_CALC;
                else if (s_axis_tlast) n_state = ST_ROOT;
            end
            ST_CALC: if (r_step == 4'd14) n_state = r_last ? ST_ROOT : ST_IDLE;
            ST_ROOT: n_state = ST_WAIT;
            ST_WAIT: if (sqrt_rsp.done) n_state = ST_OUT;
            ST_OUT:  if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_voxel_size  <= 16'd4096;
            r_range_limit <= '0;
            r_weight_x    <= 16'd4096;
            r_weight_y    <= 16'd4096;
            r_weight_z    <= 16'd4096;
            r_unknown_hit <= 1'b0;
            r_skip_centre <= 1'b0;
            r_report_raw  <= 1'b0;
            r_best_scl    <= '1;
            r_best_rep    <= '1;
            r_any         <= 1'b0;
            r_out_valid   <= 1'b0;
            r_step        <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_VOXEL_SIZE:  r_voxel_size  <= i_cfg_wdata[15:0];
                    CFG_RANGE_LIMIT: r_range_limit <= i_cfg_wdata;
                    CFG_WEIGHT_X:    r_weight_x    <= i_cfg_wdata[15:0];
                    CFG_WEIGHT_Y:    r_weight_y    <= i_cfg_wdata[15:0];
                    CFG_WEIGHT_Z:    r_weight_z    <= i_cfg_wdata[15:0];
                    CFG_UNKNOWN_HIT: r_unknown_hit <= i_cfg_wdata[0];
                    CFG_SKIP_CENTRE: r_skip_centre <= i_cfg_wdata[0];
                    CFG_REPORT_RAW:  r_report_raw  <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (r_state == ST_IDLE) r_step <= '0;
            if (r_state == ST_CALC) begin
                r_step <= r_step + 4'd1;
                if (r_step == 4'd14 && in_range && better) begin
                    r_best_scl <= scl_sat;
                    r_best_rep <= rep;
                    r_any      <= 1'b1;
                end
            end
            // A new result may replace the one taken in the same cycle.
            if (r_state == ST_OUT && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
                r_best_scl  <= '1;
                r_best_rep  <= '1;
                r_any       <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mx   <= in_mx;
            r_my   <= in_my;
            r_mz   <= in_mz;
            r_last <= s_axis_tlast;
        end
        if (r_state == ST_CALC) begin
            unique case (r_step)
                4'd1:  r_sx  <= mul_p[20:0];
                4'd2:  r_sy  <= mul_p[20:0];
                4'd3:  r_sz  <= mul_p[20:0];
                4'd4:  r_raw <= mul_p[SqW-1:0];
                4'd5:  r_raw <= r_raw + mul_p[SqW-1:0];
                4'd6:  r_raw <= r_raw + mul_p[SqW-1:0];
                4'd7:  r_cx  <= round_p[36:12];
                4'd8:  r_cy  <= round_p[36:12];
                4'd9:  r_cz  <= round_p[36:12];
                4'd10: r_scl <= {1'b0, mul_p[SqW-1:0]};
                4'd11: r_scl <= r_scl + {1'b0, mul_p[SqW-1:0]};
                4'd12: r_scl <= r_scl + {1'b0, mul_p[SqW-1:0]};
                4'd13: r_lim <= mul_p;
                default: ;
            endcase
        end
        if (r_state == ST_OUT && (!r_out_valid || m_axis_tready)) begin
            r_out_found <= r_any;
            r_out_dist  <= r_any ? 28'(sqrt_rsp.root) : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_dist};
    assign m_axis_tuser  = r_out_found;

endmodule

### rtl/novd_chk.sv
// Port-level checker for the nearest occupied voxel distance core.
// Depends on novd_pkg; bound to the top level at the end of this file.
module novd_chk import novd_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               s_axis_tlast,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [31:0]        m_axis_tdata,
    input logic               m_axis_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("non-zero distance without a find");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result present after reset");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("accepted input while finishing a query");

endmodule

bind nearest_occupied_voxel_distance_core novd_chk u_chk (.*);

### tb/tb.sv
// Self-checking bench for nearest_occupied_voxel_distance_core: drives voxel
// transfers, predicts each query's nearest distance and compares every result.
// Depends on novd_pkg and the core RTL.
module tb;
    import novd_pkg::*;

    localparam logic [51:0] SQ_CEIL  = {52{1'b1}};
    localparam int          WATCHDOG = 20000;
    localparam int          DRAIN    = 60;

    typedef struct packed {
        logic [5:0] ox;
        logic [5:0] oy;
        logic [5:0] oz;
        logic [1:0] cls;
        logic       last;
    } t_voxel;

    typedef struct packed {
        logic [27:0] distance;
        logic        found;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [27:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    nearest_occupied_voxel_distance_core uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor copy of the registers and the running query.
    logic [15:0] p_vsize = 16'd4096;
    logic [27:0] p_range = '0;
    logic [15:0] p_wx = 16'd4096, p_wy = 16'd4096, p_wz = 16'd4096;
    logic        p_unk = 1'b0, p_skip = 1'b0, p_raw = 1'b0;
    logic [51:0] best_scl = SQ_CEIL, best_rep = SQ_CEIL;
    logic        best_any = 1'b0;

    t_voxel  pending_voxels[$];
    t_answer expected_answers[$];
    int      errors = 0;
    int      send_idle = 11, recv_idle = 53;
    bit      send_hold = 1'b0;
    bit      in_taken = 1'b0;
    int      quiet = 0;

    function automatic logic [63:0] mag(input logic [5:0] v);
        return v[5] ? 64'(-$signed(v)) : 64'(v);
    endfunction

    function automatic logic [63:0] root_nearest(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        // Bitwise root: build the result from the top bit down.
        for (int i = 31; i >= 0; i--) begin
            b = r | (64'd1 << i);
            if (b * b <= v) r = b;
        end
        if (v - r * r > r) r = r + 1;
        return r;
    endfunction

    // Updates the running nearest hit with one accepted voxel; a last voxel queues the answer and starts a new query.
    task automatic absorb_voxel(input t_voxel v);
        logic [63:0] mx, my, mz, sx, sy, sz, cx, cy, cz, raw, scl, rep, lim, rt;
        logic hit;
        mx = mag(v.ox); my = mag(v.oy); mz = mag(v.oz);
        hit = (v.cls == CLS_OCCUPIED) || (v.cls == CLS_UNKNOWN && p_unk);
        if (hit && !(p_skip && mx == 0 && my == 0 && mz == 0)) begin
            sx = mx * p_vsize; sy = my * p_vsize; sz = mz * p_vsize;
            raw = sx * sx + sy * sy + sz * sz;
            if (raw > SQ_CEIL) raw = SQ_CEIL;
            cx = (sx * p_wx + 2048) >> 12;
            cy = (sy * p_wy + 2048) >> 12;
            cz = (sz * p_wz + 2048) >> 12;
            scl = cx * cx + cy * cy + cz * cz;
            if (scl > SQ_CEIL) scl = SQ_CEIL;
            rep = p_raw ? raw : scl;
            lim = 64'(p_range) * 64'(p_range);
            if ((p_range == 0 || rep <= lim) && (!best_any || scl < best_scl)) begin
                best_scl = scl[51:0];
                best_rep = rep[51:0];
                best_any = 1'b1;
            end
        end
        if (v.last) begin
            rt = root_nearest(64'(best_rep));
            expected_answers.push_back(best_any ?
                t_answer'{rt[27:0], 1'b1} : t_answer'{28'd0, 1'b0});
            best_scl = SQ_CEIL; best_rep = SQ_CEIL; best_any = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Driver: a voxel stays on the bus until a rising edge has taken it;
    // inputs move on the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || in_taken) begin
                if (pending_voxels.size() > 0 && !send_hold &&
                    $urandom_range(99) >= send_idle) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {4'b0, pending_voxels[0].cls, pending_voxels[0].oz,
                                     pending_voxels[0].oy, pending_voxels[0].ox};
                    s_axis_tlast <= pending_voxels[0].last;
                    void'(pending_voxels.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Monitor: predicts on accepted voxels and checks accepted results.
    always @(posedge i_clk) begin
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_voxel(t_voxel'{s_axis_tdata[5:0], s_axis_tdata[11:6],
                                      s_axis_tdata[17:12], s_axis_tdata[19:18],
                                      s_axis_tlast});
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, 32'd0);
                end else begin
                    if (m_axis_tdata[27:0] !== expected_answers[0].distance)
                        report_mismatch("distance", 32'(m_axis_tdata[27:0]),
                                        32'(expected_answers[0].distance));
                    if (m_axis_tdata[31:28] !== 4'b0)
                        report_mismatch("tdata padding", 32'(m_axis_tdata[31:28]), 32'd0);
                    if (m_axis_tuser !== expected_answers[0].found)
                        report_mismatch("found", 32'(m_axis_tuser),
                                        32'(expected_answers[0].found));
                    void'(expected_answers.pop_front());
                end
            end
            if (quiet >= WATCHDOG) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // A register write lands on a rising edge; the predictor follows at once.
    task automatic write_reg(input t_cfg_idx idx, input logic [27:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_addr <= idx; i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_VOXEL_SIZE:  p_vsize = val[15:0];
            CFG_RANGE_LIMIT: p_range = val;
            CFG_WEIGHT_X:    p_wx = val[15:0];
            CFG_WEIGHT_Y:    p_wy = val[15:0];
            CFG_WEIGHT_Z:    p_wz = val[15:0];
            CFG_UNKNOWN_HIT: p_unk = val[0];
            CFG_SKIP_CENTRE: p_skip = val[0];
            default:         p_raw = val[0];
        endcase
    endtask

    // Waits until every voxel is sent and every result has come back; the core
    // is then idle, and a short pad of quiet cycles follows.
    task automatic settle();
        while (pending_voxels.size() > 0 || s_axis_tvalid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic logic [5:0] rand_offset();
        return 6'($urandom_range(63));
    endfunction

    // Queues a query of n voxels with random content; x and y offsets are mostly small.
    task automatic queue_query(input int n);
        t_voxel v;
        for (int i = 0; i < n; i++) begin
            v.ox = rand_offset(); v.oy = rand_offset(); v.oz = rand_offset();
            if ($urandom_range(3) != 0) begin
                v.ox = 6'($signed($urandom_range(6)) - 3);
                v.oy = 6'($signed($urandom_range(6)) - 3);
            end
            v.cls = 2'($urandom_range(3));
            v.last = (i == n - 1);
            pending_voxels.push_back(v);
        end
    endtask

    task automatic random_config();
        write_reg(CFG_VOXEL_SIZE, $urandom_range(3) == 0 ? 28'($urandom_range(65535)) :
                                  28'($urandom_range(8192, 1)));
        write_reg(CFG_RANGE_LIMIT, $urandom_range(2) == 0 ? 28'd0 :
                                   28'($urandom_range(40000, 1)));
        write_reg(CFG_WEIGHT_X, 28'($urandom_range(65535)));
        write_reg(CFG_WEIGHT_Y, 28'($urandom_range(8192)));
        write_reg(CFG_WEIGHT_Z, 28'($urandom_range(8192)));
        write_reg(CFG_UNKNOWN_HIT, 28'($urandom_range(1)));
        write_reg(CFG_SKIP_CENTRE, 28'($urandom_range(1)));
        write_reg(CFG_REPORT_RAW, 28'($urandom_range(1)));
    endtask

    initial begin
        int sent;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: extreme offsets, every class, centre voxel, ties, class three.
        pending_voxels.push_back(t_voxel'{6'd0, 6'd0, 6'd0, 2'd1, 1'b1});
        pending_voxels.push_back(t_voxel'{6'd0, 6'd0, 6'd0, 2'd0, 1'b1});
        pending_voxels.push_back(t_voxel'{6'd31, 6'd0, 6'd0, 2'd2, 1'b0});
        pending_voxels.push_back(t_voxel'{6'd3, 6'd0, 6'd0, 2'd3, 1'b1});
        pending_voxels.push_back(t_voxel'{6'h20, 6'h20, 6'h20, 2'd1, 1'b0});
        pending_voxels.push_back(t_voxel'{6'd2, 6'd0, 6'd0, 2'd1, 1'b0});
        pending_voxels.push_back(t_voxel'{6'd0, 6'h3e, 6'd0, 2'd1, 1'b1});
        pending_voxels.push_back(t_voxel'{6'h3f, 6'h3f, 6'h3f, 2'd1, 1'b1});
        settle();
        // Maximum size, X and Z weights at maximum and Y weight zero; unknown and centre rules on.
        write_reg(CFG_VOXEL_SIZE, 28'd65535);
        write_reg(CFG_WEIGHT_X, 28'd65535);
        write_reg(CFG_WEIGHT_Y, 28'd0);
        write_reg(CFG_WEIGHT_Z, 28'd65535);
        write_reg(CFG_UNKNOWN_HIT, 28'd1);
        write_reg(CFG_SKIP_CENTRE, 28'd1);
        write_reg(CFG_REPORT_RAW, 28'd1);
        write_reg(CFG_RANGE_LIMIT, 28'hFFFFFFF);
        pending_voxels.push_back(t_voxel'{6'd0, 6'd0, 6'd0, 2'd1, 1'b0});
        pending_voxels.push_back(t_voxel'{6'h20, 6'h21, 6'h20, 2'd2, 1'b0});
        pending_voxels.push_back(t_voxel'{6'd31, 6'd31, 6'd31, 2'd1, 1'b1});
        pending_voxels.push_back(t_voxel'{6'd0, 6'd0, 6'd0, 2'd2, 1'b1});
        settle();
        write_reg(CFG_VOXEL_SIZE, 28'd1);
        write_reg(CFG_RANGE_LIMIT, 28'd1);
        write_reg(CFG_REPORT_RAW, 28'd0);
        pending_voxels.push_back(t_voxel'{6'd1, 6'd0, 6'd0, 2'd1, 1'b0});
        pending_voxels.push_back(t_voxel'{6'd0, 6'd15, 6'd0, 2'd1, 1'b1});
        settle();

        // Random phases with changing idle pattern and settings, about 100
        // voxels each.
        sent = 0;
        for (int ph = 0; ph < 12; ph++) begin
            int q;
            if (ph == 4) begin send_idle = 53; recv_idle = 11; end
            if (ph == 8) begin send_idle = 0;  recv_idle = 0;  end
            random_config();
            q = 0;
            while (sent < (ph + 1) * 100) begin
                int n;
                n = ($urandom_range(9) == 0) ? int'($urandom_range(12, 1)) :
                                               int'($urandom_range(6, 1));
                queue_query(n);
                sent += n;
                // Hold the sender once until every result has come back.
                if (ph == 2 && q == 5) begin
                    while (pending_voxels.size() > 0 || s_axis_tvalid) @(posedge i_clk);
                    send_hold = 1'b1;
                    while (expected_answers.size() > 0) @(posedge i_clk);
                    send_hold = 1'b0;
                end
                q++;
            end
            settle();
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
